// ===== rtl/annular_sector_hit_test_assert.svh =====
// Assertion macros for the annular sector hit test.
`ifndef ANNULAR_SECTOR_HIT_TEST_ASSERT_SVH
`define ANNULAR_SECTOR_HIT_TEST_ASSERT_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define ASH_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define ASH_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ash_pkg.sv =====
// Shared types, constants and tables for the annular sector hit test.
package ash_pkg;

  localparam int COORD_BITS_DEF      = 24;
  localparam int ANGLE_FRAC_BITS_DEF = 6;

  // Bearing datapath: 64-bit vector components, angle accumulator in 2^-24 degree.
  localparam int XW           = 64;
  localparam int ZW           = 35;
  localparam int ZFRAC        = 24;
  localparam int NORM_LIMIT   = 59;
  localparam int NORM_STAGES  = 6;
  localparam int CORDIC_STEPS = 28;

  localparam int NORM_SHIFT [NORM_STAGES] = '{32, 16, 8, 4, 2, 1};

  // atan(2^-i) in 2^-24 degree, rounded to nearest.
  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
    32'd30029717, 32'd15018523, 32'd7509720, 32'd3754917, 32'd1877466,
    32'd938734, 32'd469367, 32'd234684, 32'd117342, 32'd58671, 32'd29335,
    32'd14668, 32'd7334, 32'd3667, 32'd1833, 32'd917, 32'd458, 32'd229,
    32'd115, 32'd57, 32'd29, 32'd14, 32'd7
  };

  localparam logic signed [ZW-1:0] Z_90  = ZW'(90) << ZFRAC;
  localparam logic signed [ZW-1:0] Z_180 = ZW'(180) << ZFRAC;
  localparam logic signed [ZW-1:0] Z_360 = ZW'(360) << ZFRAC;

  typedef struct packed {
    logic valid;
    logic origin;
    logic neg_x;
    logic neg_y;
    logic swapped;
    logic ring_ok;
  } ash_flags_t;

endpackage

// ===== rtl/annular_sector_hit_test.sv =====
// Annular sector hit test: one test per transfer, fully pipelined.
// The in_ channel carries one test per transfer: the point, the ring centre, the
// inner and outer radius and the sector. The out_ channel returns one bit per
// test, hit, in the same order as the tests arrived.
// A new test is taken in every cycle while out_tready stays high, so the
// sustained rate is one test per clock. Once accepted, a test passes through
// five front stages for the differences, squares and ring check, six
// normalisation cells, 28 rotation cells of the bearing chain, two stages that
// unfold and round the bearing, and the output register, which shows its
// result on out_tvalid.
// The output register is backed by one skid register. When the receiver stalls
// and a further result arrives, it is parked in the skid register and
// in_tready falls; the whole pipeline then holds until the skid register
// drains into the output register.
// Reset clears every valid flag, so no result is shown until a test has passed
// through; there is no other state and no configuration.
`include "annular_sector_hit_test_assert.svh"

module annular_sector_hit_test #(
  parameter int  COORD_BITS      = ash_pkg::COORD_BITS_DEF,
  parameter int  ANGLE_FRAC_BITS = ash_pkg::ANGLE_FRAC_BITS_DEF,
  localparam int AW_P            = ANGLE_FRAC_BITS + 9,
  localparam int IN_W            = ((6 * COORD_BITS + 2 * AW_P + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  // point_x, point_y, centre_x, centre_y, inner_radius, outer_radius,
  // sector_width, sector_angle, zero fill
  input  logic [IN_W-1:0] in_tdata,
  output logic            out_tvalid,
  input  logic            out_tready,
  // hit, zero fill
  output logic [7:0]      out_tdata
);
  import ash_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int AW   = AW_P;
  localparam int BW   = AW + 1;
  localparam int SW   = 2 * BW;
  localparam int PW   = 2 * CB;
  localparam int DW   = 2 * CB + 1;
  localparam int FULL = 360 << (ANGLE_FRAC_BITS + 1);
  localparam int SH   = ZFRAC - (ANGLE_FRAC_BITS + 1);

  localparam logic signed [BW+1:0] FULL_S  = (BW + 2)'(FULL);
  localparam logic [BW+1:0]        FULL_U  = (BW + 2)'(FULL);
  localparam logic [BW+1:0]        FULL2_U = (BW + 2)'(2 * FULL);
  localparam logic signed [ZW-1:0] FULL_Z  = ZW'(FULL);
  localparam logic signed [ZW-1:0] HALF_Z  = ZW'(1) << (SH - 1);

  // Input fields.
  logic signed [CB-1:0] f_px;
  logic signed [CB-1:0] f_py;
  logic signed [CB-1:0] f_cx;
  logic signed [CB-1:0] f_cy;
  logic signed [CB-1:0] f_rin;
  logic signed [CB-1:0] f_rout;
  logic [AW-1:0]        f_wid;
  logic [AW-1:0]        f_ang;

  assign f_px   = in_tdata[CB-1:0];
  assign f_py   = in_tdata[2*CB-1:CB];
  assign f_cx   = in_tdata[3*CB-1:2*CB];
  assign f_cy   = in_tdata[4*CB-1:3*CB];
  assign f_rin  = in_tdata[5*CB-1:4*CB];
  assign f_rout = in_tdata[6*CB-1:5*CB];
  assign f_wid  = in_tdata[6*CB+AW-1:6*CB];
  assign f_ang  = in_tdata[6*CB+2*AW-1:6*CB+AW];

  logic adv;
  logic acc;

  logic skid_valid_r;
  logic skid_hit_r;
  logic out_valid_r;
  logic out_hit_r;

  assign adv       = !skid_valid_r;
  assign acc       = in_tvalid && adv;
  assign in_tready = adv;

  // Stage A: differences and sector bounds.
  logic [BW-1:0]          two_a;
  logic signed [BW+1:0]   lo_raw;
  logic [BW+1:0]          hi_raw;
  logic signed [BW+1:0]   lo_wrap;
  logic [BW+1:0]          hi_wrap;
  logic signed [CB:0]     dx_a_nxt;
  logic signed [CB:0]     dy_a_nxt;
  logic                   va_r;
  logic signed [CB:0]     dx_a_r;
  logic signed [CB:0]     dy_a_r;
  logic signed [CB-1:0]   rin_a_r;
  logic signed [CB-1:0]   rout_a_r;
  logic [SW-1:0]          side_a_r;

  assign two_a  = {f_ang, 1'b0};
  assign lo_raw = $signed({2'b00, two_a}) - $signed({3'b000, f_wid});
  assign hi_raw = {2'b00, two_a} + {3'b000, f_wid};

  // The lower bound lies within one turn below zero or above; the upper lies below three turns.
  always_comb begin
    if (lo_raw < 0) begin
      lo_wrap = lo_raw + FULL_S;
    end else if (lo_raw >= FULL_S) begin
      lo_wrap = lo_raw - FULL_S;
    end else begin
      lo_wrap = lo_raw;
    end
    if (hi_raw >= FULL2_U) begin
      hi_wrap = hi_raw - FULL2_U;
    end else if (hi_raw >= FULL_U) begin
      hi_wrap = hi_raw - FULL_U;
    end else begin
      hi_wrap = hi_raw;
    end
  end

  assign dx_a_nxt = {f_px[CB-1], f_px} - {f_cx[CB-1], f_cx};
  assign dy_a_nxt = {f_py[CB-1], f_py} - {f_cy[CB-1], f_cy};

  // Stage B: magnitudes and octant signs.
  logic signed [CB:0] ndx;
  logic signed [CB:0] ndy;
  logic [CB-1:0]      ux_b_nxt;
  logic [CB-1:0]      uy_b_nxt;
  logic               vb_r;
  logic [CB-1:0]      ux_b_r;
  logic [CB-1:0]      uy_b_r;
  logic               negx_b_r;
  logic               negy_b_r;
  logic               origin_b_r;
  logic               rin_neg_b_r;
  logic               rout_neg_b_r;
  logic [CB-2:0]      rin_m_b_r;
  logic [CB-2:0]      rout_m_b_r;
  logic [SW-1:0]      side_b_r;

  assign ndx      = -dx_a_r;
  assign ndy      = -dy_a_r;
  assign ux_b_nxt = dx_a_r[CB] ? ndx[CB-1:0] : dx_a_r[CB-1:0];
  assign uy_b_nxt = dy_a_r[CB] ? ndy[CB-1:0] : dy_a_r[CB-1:0];

  // Stage C: squares and the fold into the first octant.
  logic          swap_c;
  ash_flags_t    flags_c_nxt;
  ash_flags_t    flags_c_r;
  logic [PW-1:0] sx_c_r;
  logic [PW-1:0] sy_c_r;
  logic [PW-1:0] ri2_c_r;
  logic [PW-1:0] ro2_c_r;
  logic [CB-1:0] ax_c_r;
  logic [CB-1:0] ay_c_r;
  logic          rin_neg_c_r;
  logic          rout_neg_c_r;
  logic [SW-1:0] side_c_r;

  assign swap_c      = uy_b_r > ux_b_r;
  assign flags_c_nxt = '{valid: vb_r, origin: origin_b_r, neg_x: negx_b_r,
                         neg_y: negy_b_r, swapped: swap_c, ring_ok: 1'b0};

  // Stage D: squared distance.
  ash_flags_t    flags_d_r;
  logic [DW-1:0] d2_d_r;
  logic [PW-1:0] ri2_d_r;
  logic [PW-1:0] ro2_d_r;
  logic [CB-1:0] ax_d_r;
  logic [CB-1:0] ay_d_r;
  logic          rin_neg_d_r;
  logic          rout_neg_d_r;
  logic [SW-1:0] side_d_r;

  // Stage E: ring check.
  logic          ring_ok_nxt;
  ash_flags_t    flags_e_nxt;
  ash_flags_t    flags_e_r;
  logic [CB-1:0] ax_e_r;
  logic [CB-1:0] ay_e_r;
  logic [SW-1:0] side_e_r;

  // A sum of squares beyond 48 bits always exceeds the outer square, so the
  // full-width compare covers it.
  assign ring_ok_nxt = !rout_neg_d_r && (d2_d_r <= DW'(ro2_d_r)) &&
                       (rin_neg_d_r || (d2_d_r >= DW'(ri2_d_r)));

  always_comb begin
    flags_e_nxt         = flags_d_r;
    flags_e_nxt.ring_ok = ring_ok_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r      <= 1'b0;
      vb_r      <= 1'b0;
      flags_c_r <= '0;
      flags_d_r <= '0;
      flags_e_r <= '0;
    end else if (adv) begin
      va_r      <= acc;
      vb_r      <= va_r;
      flags_c_r <= flags_c_nxt;
      flags_d_r <= flags_c_r;
      flags_e_r <= flags_e_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_a_r       <= dx_a_nxt;
      dy_a_r       <= dy_a_nxt;
      rin_a_r      <= f_rin;
      rout_a_r     <= f_rout;
      side_a_r     <= {hi_wrap[BW-1:0], lo_wrap[BW-1:0]};

      ux_b_r       <= ux_b_nxt;
      uy_b_r       <= uy_b_nxt;
      negx_b_r     <= dx_a_r[CB];
      negy_b_r     <= dy_a_r[CB];
      origin_b_r   <= (dx_a_r == '0) && (dy_a_r == '0);
      rin_neg_b_r  <= rin_a_r[CB-1];
      rout_neg_b_r <= rout_a_r[CB-1];
      rin_m_b_r    <= rin_a_r[CB-2:0];
      rout_m_b_r   <= rout_a_r[CB-2:0];
      side_b_r     <= side_a_r;

      sx_c_r       <= PW'(ux_b_r) * PW'(ux_b_r);
      sy_c_r       <= PW'(uy_b_r) * PW'(uy_b_r);
      ri2_c_r      <= PW'(rin_m_b_r) * PW'(rin_m_b_r);
      ro2_c_r      <= PW'(rout_m_b_r) * PW'(rout_m_b_r);
      ax_c_r       <= swap_c ? uy_b_r : ux_b_r;
      ay_c_r       <= swap_c ? ux_b_r : uy_b_r;
      rin_neg_c_r  <= rin_neg_b_r;
      rout_neg_c_r <= rout_neg_b_r;
      side_c_r     <= side_b_r;

      d2_d_r       <= DW'(sx_c_r) + DW'(sy_c_r);
      ri2_d_r      <= ri2_c_r;
      ro2_d_r      <= ro2_c_r;
      ax_d_r       <= ax_c_r;
      ay_d_r       <= ay_c_r;
      rin_neg_d_r  <= rin_neg_c_r;
      rout_neg_d_r <= rout_neg_c_r;
      side_d_r     <= side_c_r;

      ax_e_r       <= ax_d_r;
      ay_e_r       <= ay_d_r;
      side_e_r     <= side_d_r;
    end
  end

  // Normalisation cells: bring the leading one of the larger component to bit 58.
  ash_flags_t    nf [NORM_STAGES+1];
  logic [XW-1:0] nx [NORM_STAGES+1];
  logic [XW-1:0] ny [NORM_STAGES+1];
  logic [SW-1:0] ns [NORM_STAGES+1];

  assign nf[0] = flags_e_r;
  assign nx[0] = XW'(ax_e_r);
  assign ny[0] = XW'(ay_e_r);
  assign ns[0] = side_e_r;

  for (genvar k = 0; k < NORM_STAGES; k++) begin : g_norm
    ash_norm_cell #(
      .SHIFT  (NORM_SHIFT[k]),
      .SIDE_W (SW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .flags_i (nf[k]),
      .x_i     (nx[k]),
      .y_i     (ny[k]),
      .side_i  (ns[k]),
      .flags_o (nf[k+1]),
      .x_o     (nx[k+1]),
      .y_o     (ny[k+1]),
      .side_o  (ns[k+1])
    );
  end

  // Rotation cells of the bearing chain.
  ash_flags_t           cf [CORDIC_STEPS+1];
  logic signed [XW-1:0] cx [CORDIC_STEPS+1];
  logic signed [XW-1:0] cy [CORDIC_STEPS+1];
  logic signed [ZW-1:0] cz [CORDIC_STEPS+1];
  logic [SW-1:0]        cs [CORDIC_STEPS+1];

  assign cf[0] = nf[NORM_STAGES];
  assign cx[0] = $signed(nx[NORM_STAGES]);
  assign cy[0] = $signed(ny[NORM_STAGES]);
  assign cz[0] = '0;
  assign cs[0] = ns[NORM_STAGES];

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    ash_cordic_cell #(
      .STEP   (k),
      .SIDE_W (SW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .flags_i (cf[k]),
      .x_i     (cx[k]),
      .y_i     (cy[k]),
      .z_i     (cz[k]),
      .side_i  (cs[k]),
      .flags_o (cf[k+1]),
      .x_o     (cx[k+1]),
      .y_o     (cy[k+1]),
      .z_o     (cz[k+1]),
      .side_o  (cs[k+1])
    );
  end

  // Stage U: unfold the octant.
  ash_flags_t           flags_last;
  logic signed [ZW-1:0] z_last;
  logic signed [ZW-1:0] z1;
  logic signed [ZW-1:0] z2;
  logic signed [ZW-1:0] z3;
  ash_flags_t           flags_u_r;
  logic signed [ZW-1:0] z_u_r;
  logic [SW-1:0]        side_u_r;

  assign flags_last = cf[CORDIC_STEPS];
  assign z_last     = cz[CORDIC_STEPS];
  assign z1 = flags_last.swapped ? (Z_90 - z_last) : z_last;
  assign z2 = flags_last.neg_x ? (Z_180 - z1) : z1;
  assign z3 = flags_last.neg_y ? (Z_360 - z2) : z2;

  // Stage R: round to half units and wrap into one turn.
  logic signed [ZW-1:0] b_raw;
  logic signed [ZW-1:0] b_wrap;
  logic [BW-1:0]        bear_nxt;
  ash_flags_t           flags_r_r;
  logic [BW-1:0]        bear_r;
  logic [SW-1:0]        side_r_r;

  assign b_raw = (z_u_r + HALF_Z) >>> SH;

  always_comb begin
    if (b_raw < 0) begin
      b_wrap = b_raw + FULL_Z;
    end else if (b_raw >= FULL_Z) begin
      b_wrap = b_raw - FULL_Z;
    end else begin
      b_wrap = b_raw;
    end
  end

  // A point on the centre has bearing zero.
  assign bear_nxt = flags_u_r.origin ? '0 : b_wrap[BW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_u_r <= '0;
      flags_r_r <= '0;
    end else if (adv) begin
      flags_u_r <= flags_last;
      flags_r_r <= flags_u_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      z_u_r    <= z3;
      side_u_r <= cs[CORDIC_STEPS];
      bear_r   <= bear_nxt;
      side_r_r <= side_u_r;
    end
  end

  // Sector test: an ordinary arc when the start lies below the end, otherwise
  // one that runs through zero degrees.
  logic [BW-1:0] sec_lo;
  logic [BW-1:0] sec_hi;
  logic          in_arc;
  logic          hit_nxt;

  assign sec_lo  = side_r_r[BW-1:0];
  assign sec_hi  = side_r_r[SW-1:BW];
  assign in_arc  = (sec_lo < sec_hi) ? ((bear_r >= sec_lo) && (bear_r <= sec_hi))
                                     : ((bear_r >= sec_lo) || (bear_r <= sec_hi));
  assign hit_nxt = flags_r_r.ring_ok && in_arc;

  // Output register with one skid register behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        if (out_tready) begin
          out_hit_r    <= skid_hit_r;
          skid_valid_r <= 1'b0;
        end
      end else if (flags_r_r.valid) begin
        if (!out_valid_r || out_tready) begin
          out_valid_r <= 1'b1;
          out_hit_r   <= hit_nxt;
        end else begin
          skid_valid_r <= 1'b1;
          skid_hit_r   <= hit_nxt;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0000000, out_hit_r};

  `ASH_ASSERT_IMP(a_skid_behind_out, skid_valid_r, out_valid_r, "skid register full while output register empty")
  `ASH_ASSERT_NXT(a_stall_parks_result, out_valid_r && !out_tready && !skid_valid_r && flags_r_r.valid, skid_valid_r && out_valid_r, "stalled result was not parked in the skid register")
  `ASH_ASSERT_NXT(a_ring_miss_no_hit, flags_r_r.valid && !flags_r_r.ring_ok && !skid_valid_r && (!out_valid_r || out_tready), out_valid_r && !out_hit_r, "hit reported for a point outside the ring")

endmodule

// ===== rtl/ash_norm_cell.sv =====
// One normalisation cell: shifts the folded vector left by a fixed amount when it is small.
module ash_norm_cell #(
  parameter int SHIFT  = 1,
  parameter int SIDE_W = 2
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  ash_pkg::ash_flags_t      flags_i,
  input  logic [ash_pkg::XW-1:0]   x_i,
  input  logic [ash_pkg::XW-1:0]   y_i,
  input  logic [SIDE_W-1:0]        side_i,
  output ash_pkg::ash_flags_t      flags_o,
  output logic [ash_pkg::XW-1:0]   x_o,
  output logic [ash_pkg::XW-1:0]   y_o,
  output logic [SIDE_W-1:0]        side_o
);
  import ash_pkg::*;

  logic            can_shift;
  logic [XW-1:0]   x_nxt;
  logic [XW-1:0]   y_nxt;
  ash_flags_t      flags_r;
  logic [XW-1:0]   x_r;
  logic [XW-1:0]   y_r;
  logic [SIDE_W-1:0] side_r;

  // The leading one has not yet reached bit NORM_LIMIT-SHIFT, so a shift cannot overflow.
  assign can_shift = (x_i[XW-1:NORM_LIMIT-SHIFT] == '0);
  assign x_nxt = can_shift ? (x_i << SHIFT) : x_i;
  assign y_nxt = can_shift ? (y_i << SHIFT) : y_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (en) begin
      flags_r <= flags_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      side_r <= side_i;
    end
  end

  assign flags_o = flags_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign side_o  = side_r;

endmodule

// ===== rtl/ash_cordic_cell.sv =====
// One vectoring rotation cell of the bearing chain.
module ash_cordic_cell #(
  parameter int STEP   = 0,
  parameter int SIDE_W = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  ash_pkg::ash_flags_t           flags_i,
  input  logic signed [ash_pkg::XW-1:0] x_i,
  input  logic signed [ash_pkg::XW-1:0] y_i,
  input  logic signed [ash_pkg::ZW-1:0] z_i,
  input  logic [SIDE_W-1:0]             side_i,
  output ash_pkg::ash_flags_t           flags_o,
  output logic signed [ash_pkg::XW-1:0] x_o,
  output logic signed [ash_pkg::XW-1:0] y_o,
  output logic signed [ash_pkg::ZW-1:0] z_o,
  output logic [SIDE_W-1:0]             side_o
);
  import ash_pkg::*;

  localparam logic signed [ZW-1:0] ANGLE = ZW'(ATAN_TAB[STEP]);

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [XW-1:0] x_nxt;
  logic signed [XW-1:0] y_nxt;
  logic signed [ZW-1:0] z_nxt;
  ash_flags_t           flags_r;
  logic signed [XW-1:0] x_r;
  logic signed [XW-1:0] y_r;
  logic signed [ZW-1:0] z_r;
  logic [SIDE_W-1:0]    side_r;

  assign xs = x_i >>> STEP;
  assign ys = y_i >>> STEP;

  // Rotate towards the x axis: the sign of y picks the direction.
  always_comb begin
    if (!y_i[XW-1]) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ANGLE;
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (en) begin
      flags_r <= flags_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      side_r <= side_i;
    end
  end

  assign flags_o = flags_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign z_o     = z_r;
  assign side_o  = side_r;

endmodule

// ===== tb/sv/annular_sector_hit_test_tb.sv =====
// Self-checking testbench for the annular sector hit test, with a bit-exact bearing predictor.
module annular_sector_hit_test_tb;

  localparam int COORD_W = ash_pkg::COORD_BITS_DEF;
  localparam int ANGLE_W = ash_pkg::ANGLE_FRAC_BITS_DEF + 9;
  localparam int IN_W    = ((6 * COORD_W + 2 * ANGLE_W + 7) / 8) * 8;
  localparam int PAD_W   = IN_W - 6 * COORD_W - 2 * ANGLE_W;

  localparam longint COORD_MAX  = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint COORD_MIN  = -(longint'(1) << (COORD_W - 1));
  localparam longint FULL_H     = longint'(360) << (ash_pkg::ANGLE_FRAC_BITS_DEF + 1);
  localparam longint WIDTH_FULL = FULL_H / 2;
  localparam int     HALF_SHIFT = 24 - (ash_pkg::ANGLE_FRAC_BITS_DEF + 1);
  localparam longint NORM_FLOOR = longint'(1) << 58;
  localparam longint Z_QUARTER  = longint'(90) << 24;
  localparam longint Z_HALF     = longint'(180) << 24;
  localparam longint Z_TURN     = longint'(360) << 24;
  localparam int     ROT_STEPS  = 28;
  localparam int     PIPE_DEPTH = 41;
  localparam int     STALL_LIMIT = 2000;

  // atan(2^-i) in 2^-24 degree.
  localparam longint ATAN_Z [ROT_STEPS] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
    58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
  };

  // Laid out exactly as in_tdata, first field in the lowest bits.
  typedef struct packed {
    logic [PAD_W-1:0]          pad;
    logic [ANGLE_W-1:0]        sector_angle;
    logic [ANGLE_W-1:0]        sector_width;
    logic signed [COORD_W-1:0] outer_radius;
    logic signed [COORD_W-1:0] inner_radius;
    logic signed [COORD_W-1:0] centre_y;
    logic signed [COORD_W-1:0] centre_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_x;
  } hit_test_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  // point_x, point_y, centre_x, centre_y, inner_radius, outer_radius,
  // sector_width, sector_angle, zero fill
  logic [IN_W-1:0] in_tdata = '0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  // hit, zero fill
  logic [7:0]      out_tdata;

  bit expected_hits [$];
  int failures = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idling_mode = 0;
  int quiet_cycles = 0;

  annular_sector_hit_test u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint rand_between(longint lo, longint hi);
    return lo + longint'($urandom_range(int'(hi - lo), 0));
  endfunction

  // Bearing of (dx, dy) in half units of the angle step, in [0, FULL_H).
  function automatic longint bearing_half_units(longint dx, longint dy);
    longint ax, ay, tmp, x, y, z, xs, ys, b;
    bit swapped;
    if (dx == 0 && dy == 0) return 0;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    swapped = 1'b0;
    if (ay > ax) begin
      tmp = ax;
      ax = ay;
      ay = tmp;
      swapped = 1'b1;
    end
    while (ax < NORM_FLOOR) begin
      ax = ax * 2;
      ay = ay * 2;
    end
    x = ax;
    y = ay;
    z = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys;
        y -= xs;
        z += ATAN_Z[i];
      end else begin
        x -= ys;
        y += xs;
        z -= ATAN_Z[i];
      end
    end
    if (swapped) z = Z_QUARTER - z;
    if (dx < 0) z = Z_HALF - z;
    if (dy < 0) z = Z_TURN - z;
    b = (z + (longint'(1) << (HALF_SHIFT - 1))) >>> HALF_SHIFT;
    if (b < 0) b += FULL_H;
    if (b >= FULL_H) b -= FULL_H;
    return b;
  endfunction

  function automatic bit predict_hit(hit_test_t t);
    longint dx, dy, rin, rout, w, a, st, en, b;
    longint unsigned ux, uy;
    logic [64:0] d2;
    dx = longint'($signed(t.point_x)) - longint'($signed(t.centre_x));
    dy = longint'($signed(t.point_y)) - longint'($signed(t.centre_y));
    rin = longint'($signed(t.inner_radius));
    rout = longint'($signed(t.outer_radius));
    ux = (dx < 0) ? -dx : dx;
    uy = (dy < 0) ? -dy : dy;
    d2 = {1'b0, ux * ux} + {1'b0, uy * uy};
    if (rout < 0 || d2[64] || d2 > 65'(rout * rout)) return 1'b0;
    if (rin >= 0 && d2 < 65'(rin * rin)) return 1'b0;
    w = longint'(t.sector_width);
    a = longint'(t.sector_angle);
    st = ((2 * a - w) % FULL_H + FULL_H) % FULL_H;
    en = ((2 * a + w) % FULL_H + FULL_H) % FULL_H;
    b = bearing_half_units(dx, dy);
    if (st < en) return b >= st && b <= en;
    return b >= st || b <= en;
  endfunction

  function automatic hit_test_t make_test(longint px, longint py, longint cx, longint cy,
                                          longint rin, longint rout, longint w, longint a);
    hit_test_t t;
    t.pad = '0;
    t.point_x = COORD_W'(px);
    t.point_y = COORD_W'(py);
    t.centre_x = COORD_W'(cx);
    t.centre_y = COORD_W'(cy);
    t.inner_radius = COORD_W'(rin);
    t.outer_radius = COORD_W'(rout);
    t.sector_width = ANGLE_W'(w);
    t.sector_angle = ANGLE_W'(a);
    return t;
  endfunction

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 61;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 61;
      end
      default: begin
        send_idle_pct = 21;
        recv_stall_pct = 21;
      end
    endcase
  endtask

  // Called and returns at a falling edge; in_tvalid stays high for a back-to-back transfer.
  task automatic send_test(hit_test_t t);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= t;
    do @(posedge clk); while (!in_tready);
    expected_hits.push_back(predict_hit(t));
    @(negedge clk);
  endtask

  task automatic test_field_extremes();
    send_test(make_test(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                        WIDTH_FULL, WIDTH_FULL - 1));
    send_test(make_test(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX,
                        32767, 32767));
    send_test(make_test(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                        0, 0));
    send_test(make_test(0, 0, 0, 0, 0, 0, 0, 0));
    send_test(make_test(-1, -1, -1, -1, -1, -1, 32767, 32767));
    send_test(make_test(COORD_MAX, 0, COORD_MIN, 0, 0, COORD_MAX, 0, 0));
    // Distance exactly equal to both radii at the largest representable value.
    send_test(make_test(COORD_MAX, 0, 0, 0, COORD_MAX, COORD_MAX, 0, 0));
  endtask

  task automatic test_special_cases();
    // Bearings along each axis, each inside a narrow sector, then one outside it.
    send_test(make_test(100, 0, 0, 0, -1, 200, 64, 0));
    send_test(make_test(0, 100, 0, 0, -1, 200, 64, 5760));
    send_test(make_test(-100, 0, 0, 0, -1, 200, 64, 11520));
    send_test(make_test(0, -100, 0, 0, -1, 200, 64, 17280));
    send_test(make_test(100, 0, 0, 0, -1, 200, 64, 5760));
    // Point at the centre.
    send_test(make_test(-321, 654, -321, 654, -1, 0, 64, 11520));
    send_test(make_test(-321, 654, -321, 654, -5, -1, 0, 0));
    // Exact ring boundaries on a 3-4-5 offset.
    send_test(make_test(1048, -1936, 1000, -2000, 80, 80, 0, 0));
    send_test(make_test(1048, -1936, 1000, -2000, 81, 90, 0, 0));
    send_test(make_test(1048, -1936, 1000, -2000, 10, 79, 0, 0));
    // Sector that wraps through zero bearing.
    send_test(make_test(1000, -9, 0, 0, -1, 2000, 128, 0));
    send_test(make_test(1000, -9, 0, 0, -1, 2000, 4, 0));
    // Full turn, inner above outer, no inner limit.
    send_test(make_test(-777, 333, 10, 20, 0, 5000, WIDTH_FULL, 777));
    send_test(make_test(100, 0, 0, 0, 300, 200, 0, 0));
    send_test(make_test(3, 4, 0, 0, COORD_MIN, 5, 0, 0));
  endtask

  // Well-formed tests: radii mostly placed around the actual distance, sectors often near the bearing.
  task automatic test_ring_random(int count);
    hit_test_t t;
    longint cx, cy, dx, dy, r, rin, rout, w, a;
    int scale;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) set_idling(idling_mode++);
      cx = rand_between(-(COORD_MAX / 2), COORD_MAX / 2);
      cy = rand_between(-(COORD_MAX / 2), COORD_MAX / 2);
      scale = $urandom_range(21, 0);
      dx = rand_between(-(longint'(1) << scale), longint'(1) << scale);
      dy = rand_between(-(longint'(1) << scale), longint'(1) << scale);
      r = longint'($sqrt(real'(dx * dx + dy * dy)));
      case ($urandom_range(3, 0))
        0: begin
          rout = r + rand_between(-1, 1);
          rin = -rand_between(1, -COORD_MIN);
        end
        1: begin
          rout = r + rand_between(0, 1000);
          rin = r + rand_between(-1, 1);
        end
        2: begin
          rout = rand_between(0, COORD_MAX);
          rin = rand_between(0, rout);
        end
        default: begin
          rout = r + rand_between(-2, 2);
          rin = r - rand_between(0, 2);
        end
      endcase
      w = rand_between(0, WIDTH_FULL);
      if ($urandom_range(1, 0))
        a = rand_between(0, WIDTH_FULL - 1);
      else
        a = ((bearing_half_units(dx, dy) / 2 + rand_between(-200, 200)) % WIDTH_FULL
             + WIDTH_FULL) % WIDTH_FULL;
      t = make_test(cx + dx, cy + dy, cx, cy, rin, rout, w, a);
      send_test(t);
    end
  endtask

  // Sector start or end placed on the bearing or one half unit either side of it.
  task automatic test_sector_edges(int count);
    longint cx, cy, dx, dy, b, w, edge_pos;
    int scale;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) set_idling(idling_mode++);
      cx = rand_between(-(COORD_MAX / 2), COORD_MAX / 2);
      cy = rand_between(-(COORD_MAX / 2), COORD_MAX / 2);
      scale = $urandom_range(21, 0);
      dx = rand_between(-(longint'(1) << scale), longint'(1) << scale);
      dy = rand_between(-(longint'(1) << scale), longint'(1) << scale);
      b = bearing_half_units(dx, dy) + rand_between(-1, 1);
      w = rand_between(0, WIDTH_FULL);
      if ((b + w) % 2 != 0) w = (w == 0) ? 1 : w - 1;
      edge_pos = $urandom_range(1, 0) ? b + w : b - w;
      edge_pos = (edge_pos % FULL_H + FULL_H) % FULL_H;
      send_test(make_test(cx + dx, cy + dy, cx, cy, -rand_between(0, 1), COORD_MAX,
                          w, edge_pos / 2));
    end
  endtask

  // Every field fully random, sector fields over their whole 15-bit range.
  task automatic test_noise(int count);
    hit_test_t t;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) set_idling(idling_mode++);
      t = make_test($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                    $urandom(), $urandom());
      send_test(t);
    end
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    bit want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_hits.size() == 0) begin
        $error("hit: result transfer with no test outstanding, got %0d", out_tdata[0]);
        failures++;
      end else begin
        want = expected_hits.pop_front();
        if (out_tdata[0] !== want) begin
          $error("hit: expected %0d, actual %0d", want, out_tdata[0]);
          failures++;
        end
      end
    end
  end

  // Ends the run when neither channel has moved for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    set_idling(0);
    test_field_extremes();
    test_special_cases();
    test_ring_random(800);
    test_sector_edges(400);
    test_noise(150);
    in_tvalid <= 1'b0;
    set_idling(0);
    while (expected_hits.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 4) @(negedge clk);
    if (failures == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ash_pkg.sv
rtl/ash_norm_cell.sv
rtl/ash_cordic_cell.sv
rtl/annular_sector_hit_test.sv
tb/sv/annular_sector_hit_test_tb.sv
